@@ sv/f32alu_pkg.sv @@
package f32alu_pkg;

    localparam int MAG_W      = 50;
    localparam int EXP_W      = 12;
    localparam int REM_W      = 25;
    localparam int QUO_W      = 28;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic        last_in;
    } operand_beat_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        zero_divisor;
        logic        last_out;
    } result_beat_t;

    typedef struct packed {
        logic                    last;
        logic                    spec;
        logic [31:0]             spec_bits;
        logic                    dz;
        logic                    sign;
        logic signed [EXP_W-1:0] exp;
        logic [MAG_W-1:0]        mag;
    } norm_in_t;

    function automatic logic [5:0] lzc_mag(input logic [MAG_W-1:0] v);
        logic [5:0] n;
        n = 6'(MAG_W);
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                n = 6'(MAG_W - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc_man(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/float32_elementwise_alu.sv @@
// Single-precision add, subtract, multiply and divide, one beat per element.
// Operand channel: operands_valid / operands_ready carry mode, operand_a,
// operand_b and last_in. Result channel: result_valid / result_ready carry
// result_bits, zero_divisor and last_out. Results leave in the order taken.
// From acceptance to result_valid each element passes through unpack, operand
// preparation (multiplier, mantissa normalise, magnitude compare), fourteen
// divider stages retiring two quotient bits each, then leading-zero count,
// normalise shift, denormalise shift and round. Every operation takes the
// full depth, so latency does not depend on mode.
// Throughput is one element per cycle while result_ready is high.
// Rounding is to nearest, ties to even; every NaN result is 0x7FC00000.
// A zero divisor of either sign in divide mode gives +0.0 with zero_divisor set.
// Reset empties the pipeline; no state survives between elements.
// When the receiver stalls, the whole pipeline holds and operands_ready drops
// in the same cycle, so no beat is lost or repeated.
module float32_elementwise_alu
    import f32alu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          operands_valid,
    output logic          operands_ready,
    input  operand_beat_t operands,
    output logic          result_valid,
    input  logic          result_ready,
    output result_beat_t  result
);

    typedef struct packed {
        logic [1:0]  mode;
        logic        last;
        logic        spec;
        logic [31:0] spec_bits;
        logic        dz;
        logic        sa;
        logic        sb;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
    } s0_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic                    last;
        logic                    spec;
        logic [31:0]             spec_bits;
        logic                    dz;
        logic                    sign;
        logic signed [EXP_W-1:0] exp;
        logic                    sub;
        logic [23:0]             big;
        logic [23:0]             small_m;
        logic [5:0]              diff;
        logic [47:0]             prod;
        logic [23:0]             na;
        logic [23:0]             nb;
    } s1_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic                    last;
        logic                    spec;
        logic [31:0]             spec_bits;
        logic                    dz;
        logic                    sign;
        logic signed [EXP_W-1:0] exp;
        logic [MAG_W-1:0]        mag;
        logic [REM_W-1:0]        rem;
        logic [QUO_W-1:0]        quo;
        logic [23:0]             den;
    } core_t;

    function automatic core_t div_step(input core_t c);
        core_t r;
        logic  q;
        r = c;
        if (c.mode == MODE_DIV)
        begin
            for (int i = 0; i < DIV_BITS; i++)
            begin
                q = (r.rem >= {1'b0, r.den});
                if (q)
                begin
                    r.rem = r.rem - {1'b0, r.den};
                end
                r.quo = {r.quo[QUO_W-2:0], q};
                r.rem = {r.rem[REM_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic  advance;
    logic  s0_valid_reg, s1_valid_reg;
    s0_t   s0_reg, s0_next;
    s1_t   s1_reg, s1_next;
    core_t s2_next;
    logic  core_valid_reg [DIV_STAGES];
    core_t core_reg       [DIV_STAGES];

    logic [7:0]  ae, be;
    logic        a_zero, a_inf, a_nan, b_zero, b_inf, b_nan, sbe_in, sx_in;

    logic        sbe, a_ge;
    logic [7:0]  big_e, small_e, dexp;
    logic [4:0]  lza, lzb;

    logic [MAG_W-1:0] bw, sw_full, sw;

    norm_in_t tail;

    assign advance        = !result_valid || result_ready;
    assign operands_ready = advance;

    always_comb
    begin
        ae     = operands.operand_a[30:23];
        be     = operands.operand_b[30:23];
        a_zero = (ae == 8'd0) && (operands.operand_a[22:0] == '0);
        b_zero = (be == 8'd0) && (operands.operand_b[22:0] == '0);
        a_inf  = (ae == 8'hFF) && (operands.operand_a[22:0] == '0);
        b_inf  = (be == 8'hFF) && (operands.operand_b[22:0] == '0);
        a_nan  = (ae == 8'hFF) && (operands.operand_a[22:0] != '0);
        b_nan  = (be == 8'hFF) && (operands.operand_b[22:0] != '0);
        sbe_in = operands.operand_b[31] ^ (operands.mode == MODE_SUB);
        sx_in  = operands.operand_a[31] ^ operands.operand_b[31];

        s0_next.mode = operands.mode;
        s0_next.last = operands.last_in;
        s0_next.sa   = operands.operand_a[31];
        s0_next.sb   = operands.operand_b[31];
        s0_next.ea   = (ae == 8'd0) ? 8'd1 : ae;
        s0_next.eb   = (be == 8'd0) ? 8'd1 : be;
        s0_next.ma   = {ae != 8'd0, operands.operand_a[22:0]};
        s0_next.mb   = {be != 8'd0, operands.operand_b[22:0]};
        s0_next.dz   = 1'b0;
        s0_next.spec = 1'b1;
        s0_next.spec_bits = CANON_NAN;

        case (operands.mode)
            MODE_ADD, MODE_SUB:
            begin
                if (a_nan || b_nan)
                begin
                    s0_next.spec_bits = CANON_NAN;
                end
                else if (a_inf && b_inf)
                begin
                    s0_next.spec_bits = (operands.operand_a[31] == sbe_in)
                                      ? {sbe_in, 8'hFF, 23'd0} : CANON_NAN;
                end
                else if (a_inf)
                begin
                    s0_next.spec_bits = {operands.operand_a[31], 8'hFF, 23'd0};
                end
                else if (b_inf)
                begin
                    s0_next.spec_bits = {sbe_in, 8'hFF, 23'd0};
                end
                else if (a_zero && b_zero)
                begin
                    s0_next.spec_bits = {operands.operand_a[31] & sbe_in, 31'd0};
                end
                else
                begin
                    s0_next.spec = 1'b0;
                end
            end
            MODE_MUL:
            begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                begin
                    s0_next.spec_bits = CANON_NAN;
                end
                else if (a_inf || b_inf)
                begin
                    s0_next.spec_bits = {sx_in, 8'hFF, 23'd0};
                end
                else if (a_zero || b_zero)
                begin
                    s0_next.spec_bits = {sx_in, 31'd0};
                end
                else
                begin
                    s0_next.spec = 1'b0;
                end
            end
            default:
            begin
                if (b_zero)
                begin
                    s0_next.spec_bits = POS_ZERO;
                    s0_next.dz        = 1'b1;
                end
                else if (a_nan || b_nan || (a_inf && b_inf))
                begin
                    s0_next.spec_bits = CANON_NAN;
                end
                else if (a_inf)
                begin
                    s0_next.spec_bits = {sx_in, 8'hFF, 23'd0};
                end
                else if (b_inf || a_zero)
                begin
                    s0_next.spec_bits = {sx_in, 31'd0};
                end
                else
                begin
                    s0_next.spec = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        sbe     = s0_reg.sb ^ (s0_reg.mode == MODE_SUB);
        a_ge    = ({s0_reg.ea, s0_reg.ma} >= {s0_reg.eb, s0_reg.mb});
        big_e   = a_ge ? s0_reg.ea : s0_reg.eb;
        small_e = a_ge ? s0_reg.eb : s0_reg.ea;
        dexp    = big_e - small_e;
        lza     = lzc_man(s0_reg.ma);
        lzb     = lzc_man(s0_reg.mb);

        s1_next.mode      = s0_reg.mode;
        s1_next.last      = s0_reg.last;
        s1_next.spec      = s0_reg.spec;
        s1_next.spec_bits = s0_reg.spec_bits;
        s1_next.dz        = s0_reg.dz;
        s1_next.sub       = s0_reg.sa ^ sbe;
        s1_next.big       = a_ge ? s0_reg.ma : s0_reg.mb;
        s1_next.small_m   = a_ge ? s0_reg.mb : s0_reg.ma;
        s1_next.diff      = (dexp > 8'd63) ? 6'd63 : dexp[5:0];
        s1_next.prod      = 48'(s0_reg.ma) * 48'(s0_reg.mb);
        s1_next.na        = s0_reg.ma << lza;
        s1_next.nb        = s0_reg.mb << lzb;

        case (s0_reg.mode)
            MODE_ADD, MODE_SUB:
            begin
                s1_next.sign = a_ge ? s0_reg.sa : sbe;
                s1_next.exp  = $signed(EXP_W'(big_e));
            end
            MODE_MUL:
            begin
                s1_next.sign = s0_reg.sa ^ s0_reg.sb;
                s1_next.exp  = $signed(EXP_W'(s0_reg.ea)) + $signed(EXP_W'(s0_reg.eb))
                             - EXP_W'(127);
            end
            default:
            begin
                s1_next.sign = s0_reg.sa ^ s0_reg.sb;
                s1_next.exp  = $signed(EXP_W'(s0_reg.ea)) - $signed(EXP_W'(lza))
                             - $signed(EXP_W'(s0_reg.eb)) + $signed(EXP_W'(lzb))
                             + EXP_W'(127);
            end
        endcase
    end

    always_comb
    begin
        bw      = {1'b0, s1_reg.big, 25'd0};
        sw_full = {1'b0, s1_reg.small_m, 25'd0};
        sw      = (sw_full >> s1_reg.diff);
        sw[0]   = sw[0] | ((sw_full & ~({MAG_W{1'b1}} << s1_reg.diff)) != '0);

        s2_next.mode      = s1_reg.mode;
        s2_next.last      = s1_reg.last;
        s2_next.spec      = s1_reg.spec;
        s2_next.spec_bits = s1_reg.spec_bits;
        s2_next.dz        = s1_reg.dz;
        s2_next.sign      = s1_reg.sign;
        s2_next.exp       = s1_reg.exp;
        s2_next.rem       = {1'b0, s1_reg.na};
        s2_next.quo       = '0;
        s2_next.den       = s1_reg.nb;
        if (s1_reg.mode == MODE_MUL)
        begin
            s2_next.mag = {s1_reg.prod, 2'b00};
        end
        else if (s1_reg.sub)
        begin
            s2_next.mag = bw - sw;
        end
        else
        begin
            s2_next.mag = bw + sw;
        end
        s2_next = div_step(s2_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                core_valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s0_valid_reg      <= operands_valid;
            s1_valid_reg      <= s0_valid_reg;
            core_valid_reg[0] <= s1_valid_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                core_valid_reg[k] <= core_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg      <= s0_next;
            s1_reg      <= s1_next;
            core_reg[0] <= s2_next;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                core_reg[k] <= div_step(core_reg[k-1]);
            end
        end
    end

    always_comb
    begin
        tail.last      = core_reg[DIV_STAGES-1].last;
        tail.spec      = core_reg[DIV_STAGES-1].spec;
        tail.spec_bits = core_reg[DIV_STAGES-1].spec_bits;
        tail.dz        = core_reg[DIV_STAGES-1].dz;
        tail.sign      = core_reg[DIV_STAGES-1].sign;
        tail.exp       = core_reg[DIV_STAGES-1].exp;
        if (core_reg[DIV_STAGES-1].mode == MODE_DIV)
        begin
            tail.mag    = {1'b0, core_reg[DIV_STAGES-1].quo, (MAG_W-1-QUO_W)'(0)};
            tail.mag[0] = (core_reg[DIV_STAGES-1].rem != '0);
        end
        else
        begin
            tail.mag = core_reg[DIV_STAGES-1].mag;
        end
    end

    f32alu_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .src_valid (core_valid_reg[DIV_STAGES-1]),
        .src       (tail),
        .dst_valid (result_valid),
        .dst       (result)
    );

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_divisor |-> result.result_bits == POS_ZERO)
        else $error("zero_divisor beat without +0.0 result");

    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_bits[30:23] == 8'hFF)
        && (result.result_bits[22:0] != '0) |-> result.result_bits == CANON_NAN)
        else $error("non-canonical NaN on result");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid_reg[DIV_STAGES-1] && (core_reg[DIV_STAGES-1].mode == MODE_DIV)
        && !core_reg[DIV_STAGES-1].spec
        |-> core_reg[DIV_STAGES-1].quo[QUO_W-1:QUO_W-2] != 2'b00)
        else $error("quotient below one half");

endmodule

@@ sv/f32alu_round.sv @@
module f32alu_round
    import f32alu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         src_valid,
    input  norm_in_t     src,
    output logic         dst_valid,
    output result_beat_t dst
);

    typedef struct packed {
        norm_in_t   n;
        logic       zero;
        logic [5:0] lz;
    } r1_t;

    typedef struct packed {
        logic                    last;
        logic                    spec;
        logic [31:0]             spec_bits;
        logic                    dz;
        logic                    sign;
        logic                    zero;
        logic signed [EXP_W-1:0] en;
        logic [MAG_W-1:0]        nm;
    } r2_t;

    typedef struct packed {
        logic        last;
        logic        spec;
        logic [31:0] spec_bits;
        logic        dz;
        logic        sign;
        logic        zero;
        logic        ovf;
        logic [7:0]  efld;
        logic [23:0] m24;
        logic        g;
        logic        st;
    } r3_t;

    logic         r1_valid_reg, r2_valid_reg, r3_valid_reg, out_valid_reg;
    r1_t          r1_reg, r1_next;
    r2_t          r2_reg, r2_next;
    r3_t          r3_reg, r3_next;
    result_beat_t out_reg, out_next;

    logic signed [EXP_W-1:0] one_minus;
    logic [5:0]              sh;
    logic [MAG_W-1:0]        dn;
    logic [30:0]             pk;
    logic                    inc;

    always_comb
    begin
        r1_next.n    = src;
        r1_next.zero = (src.mag == '0);
        r1_next.lz   = lzc_mag(src.mag);
    end

    always_comb
    begin
        r2_next.last      = r1_reg.n.last;
        r2_next.spec      = r1_reg.n.spec;
        r2_next.spec_bits = r1_reg.n.spec_bits;
        r2_next.dz        = r1_reg.n.dz;
        r2_next.sign      = r1_reg.n.sign;
        r2_next.zero      = r1_reg.zero;
        r2_next.nm        = r1_reg.n.mag << r1_reg.lz;
        r2_next.en        = r1_reg.n.exp + EXP_W'(1) - $signed(EXP_W'(r1_reg.lz));
    end

    always_comb
    begin
        one_minus = EXP_W'(1) - r2_reg.en;
        if (r2_reg.en >= EXP_W'(1))
        begin
            sh = 6'd0;
        end
        else if (one_minus > EXP_W'(63))
        begin
            sh = 6'd63;
        end
        else
        begin
            sh = one_minus[5:0];
        end
        dn                = r2_reg.nm >> sh;
        r3_next.last      = r2_reg.last;
        r3_next.spec      = r2_reg.spec;
        r3_next.spec_bits = r2_reg.spec_bits;
        r3_next.dz        = r2_reg.dz;
        r3_next.sign      = r2_reg.sign;
        r3_next.zero      = r2_reg.zero;
        r3_next.ovf       = (r2_reg.en > EXP_W'(254));
        r3_next.efld      = (r2_reg.en >= EXP_W'(1)) ? r2_reg.en[7:0] : 8'd0;
        r3_next.m24       = dn[MAG_W-1 -: 24];
        r3_next.g         = dn[MAG_W-25];
        r3_next.st        = (dn[MAG_W-26:0] != '0)
                          || ((r2_reg.nm & ~({MAG_W{1'b1}} << sh)) != '0);
    end

    always_comb
    begin
        inc = r3_reg.g & (r3_reg.st | r3_reg.m24[0]);
        pk  = {r3_reg.efld, r3_reg.m24[22:0]} + 31'(inc);
        out_next.zero_divisor = r3_reg.dz;
        out_next.last_out     = r3_reg.last;
        if (r3_reg.spec)
        begin
            out_next.result_bits = r3_reg.spec_bits;
        end
        else if (r3_reg.zero)
        begin
            out_next.result_bits = POS_ZERO;
        end
        else if (r3_reg.ovf || (pk[30:23] == 8'hFF))
        begin
            out_next.result_bits = {r3_reg.sign, 8'hFF, 23'd0};
        end
        else
        begin
            out_next.result_bits = {r3_reg.sign, pk};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            r3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            r1_valid_reg  <= src_valid;
            r2_valid_reg  <= r1_valid_reg;
            r3_valid_reg  <= r2_valid_reg;
            out_valid_reg <= r3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
            r3_reg  <= r3_next;
            out_reg <= out_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst       = out_reg;

endmodule
